### sv/vpwfd_pkg.sv
`default_nettype none

package vpwfd_pkg;

    // Field widths
    localparam int WIDTH_W  = 15;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 4;
    localparam int STATUS_W = 4;
    localparam int KIND_W   = 2;
    localparam int BIT_W    = 3;

    // Largest number of data or response bytes in one capture
    localparam logic [COUNT_W-1:0] MAX_BYTES = 4'd12;

    // Result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_SHORT_MIN  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SHORT_MAX  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LONG_MAX   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MARK_MAX   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_POLARITY   = 3'd4;

    localparam logic [WIDTH_W-1:0] RST_SHORT_MIN = 15'd34;
    localparam logic [WIDTH_W-1:0] RST_SHORT_MAX = 15'd96;
    localparam logic [WIDTH_W-1:0] RST_LONG_MAX  = 15'd163;
    localparam logic [WIDTH_W-1:0] RST_MARK_MAX  = 15'd239;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESP   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

    // Frame status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 4'd0;
    localparam logic [STATUS_W-1:0] ST_RESP    = 4'd1;
    localparam logic [STATUS_W-1:0] ST_BREAK   = 4'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 4'd3;
    localparam logic [STATUS_W-1:0] ST_NOSOF   = 4'd4;
    localparam logic [STATUS_W-1:0] ST_BADSYM  = 4'd5;
    localparam logic [STATUS_W-1:0] ST_FRAMING = 4'd6;
    localparam logic [STATUS_W-1:0] ST_TOOLONG = 4'd7;
    localparam logic [STATUS_W-1:0] ST_SHORT   = 4'd8;
    localparam logic [STATUS_W-1:0] ST_BADCRC  = 4'd9;

    // Decoder phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RUN  = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    // Width classes
    localparam logic [2:0] CL_BAD   = 3'd0;
    localparam logic [2:0] CL_SHORT = 3'd1;
    localparam logic [2:0] CL_LONG  = 3'd2;
    localparam logic [2:0] CL_MARK  = 3'd3;
    localparam logic [2:0] CL_BRK   = 3'd4;

    // CRC-8, polynomial 0x1D, init 0xFF; good residue over data plus CRC byte
    localparam logic [BYTE_W-1:0] CRC_POLY    = 8'h1D;
    localparam logic [BYTE_W-1:0] CRC_INIT    = 8'hFF;
    localparam logic [BYTE_W-1:0] CRC_RESIDUE = 8'hC4;

    // One result item as it sits in the result queue
    typedef struct packed {
        logic                last;
        logic [KIND_W-1:0]   kind;
        logic                norm_bit_long;
        logic                norm_bit_seen;
        logic                eod_seen;
        logic [COUNT_W-1:0]  response_count;
        logic [COUNT_W-1:0]  data_count;
        logic [STATUS_W-1:0] frame_status;
        logic [BYTE_W-1:0]   byte_value;
    } result_t;

    function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] r;
        r = crc ^ data;
        for (int i = 0; i < BYTE_W; i++) begin
            r = r[BYTE_W-1] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/vpw_pulse_frame_decoder_core.sv
`default_nettype none

// J1850 VPW receive decoder. Each input item is one timed bus pulse (level and
// width in microseconds); the decoder skips leading idle, finds SOF, break or a
// response-only start, turns widths into MSB-first bits and hands out every
// completed data or response byte, followed by one final status item (tlast
// high) when the capture ends, by capture_end or by a zero-width marker. One
// pulse is taken per clock unless the slave side stalls: the pulse register
// feeds a single pass of decode logic that writes up to two results into a
// four-entry result queue, so a result passes through the pulse register and the
// result queue before it appears on the master side. The slave side stalls only
// while that queue holds more than two items. The threshold and polarity
// registers are to be written while no capture is in progress.
module vpw_pulse_frame_decoder_core
    import vpwfd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // Pulse input
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,   // [0] pulse_level, [15:1] width_us
    input  wire logic                  s_tuser,   // [0] capture_start
    input  wire logic                  s_tlast,   // capture_end

    // Result output
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [7:0] byte_value, [11:8] frame_status, [15:12] data_count,
    // [19:16] response_count, [20] eod_seen, [21] norm_bit_seen,
    // [22] norm_bit_long, [23] zero
    output logic [23:0]                m_tdata,
    output logic [KIND_W-1:0]          m_tuser,   // [1:0] item_kind
    output logic                       m_tlast,

    // Configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [WIDTH_W-1:0]   short_min_reg;
    logic [WIDTH_W-1:0]   short_max_reg;
    logic [WIDTH_W-1:0]   long_max_reg;
    logic [WIDTH_W-1:0]   mark_max_reg;
    logic                 polarity_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel & penable & pwrite & pready;

    // Write selected register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_min_reg <= RST_SHORT_MIN;
            short_max_reg <= RST_SHORT_MAX;
            long_max_reg  <= RST_LONG_MAX;
            mark_max_reg  <= RST_MARK_MAX;
            polarity_reg  <= 1'b1;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_SHORT_MIN: short_min_reg <= pwdata[WIDTH_W-1:0];
                REG_SHORT_MAX: short_max_reg <= pwdata[WIDTH_W-1:0];
                REG_LONG_MAX:  long_max_reg  <= pwdata[WIDTH_W-1:0];
                REG_MARK_MAX:  mark_max_reg  <= pwdata[WIDTH_W-1:0];
                REG_POLARITY:  polarity_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_SHORT_MIN: prdata = APB_DATA_W'(short_min_reg);
            REG_SHORT_MAX: prdata = APB_DATA_W'(short_max_reg);
            REG_LONG_MAX:  prdata = APB_DATA_W'(long_max_reg);
            REG_MARK_MAX:  prdata = APB_DATA_W'(mark_max_reg);
            REG_POLARITY:  prdata = APB_DATA_W'(polarity_reg);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pulse register
    // ------------------------------------------------------------------
    logic               in_vld_reg;
    logic               in_start_reg;
    logic               in_lvl_reg;
    logic [WIDTH_W-1:0] in_width_reg;
    logic               in_end_reg;
    logic [QCNT_W-1:0]  q_cnt_reg;
    logic               proc_fire;
    logic               s_fire;

    assign proc_fire = in_vld_reg && (q_cnt_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign s_tready  = !in_vld_reg || proc_fire;
    assign s_fire    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    // Capture payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_start_reg <= s_tuser;
            in_lvl_reg   <= s_tdata[0];
            in_width_reg <= s_tdata[WIDTH_W:1];
            in_end_reg   <= s_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Decoder state
    // ------------------------------------------------------------------
    logic [1:0]          phase_reg,    phase_next;
    logic                exp_lvl_reg,  exp_lvl_next;
    logic                in_resp_reg,  in_resp_next;
    logic                await_nb_reg, await_nb_next;
    logic [BIT_W-1:0]    bit_idx_reg,  bit_idx_next;
    logic [BYTE_W-1:0]   shift_reg,    shift_next;
    logic [COUNT_W-1:0]  data_len_reg, data_len_next;
    logic [COUNT_W-1:0]  resp_len_reg, resp_len_next;
    logic [BYTE_W-1:0]   crc_reg,      crc_next;
    logic                eod_reg,      eod_next;
    logic                nb_reg,       nb_next;
    logic                nbl_reg,      nbl_next;
    logic [STATUS_W-1:0] status_reg,   status_next;

    logic                byte_vld;
    logic [KIND_W-1:0]   byte_kind;
    logic [STATUS_W-1:0] byte_status;
    logic                fin_vld;
    logic [STATUS_W-1:0] fin_status;
    logic                conc;
    logic                active;
    logic [2:0]          cls;
    logic                one_bit;
    logic [COUNT_W-1:0]  cur_len;

    // Classify width against the thresholds in order
    always_comb begin
        if (in_width_reg < short_min_reg) begin
            cls = CL_BAD;
        end else if (in_width_reg <= short_max_reg) begin
            cls = CL_SHORT;
        end else if (in_width_reg <= long_max_reg) begin
            cls = CL_LONG;
        end else if (in_width_reg <= mark_max_reg) begin
            cls = CL_MARK;
        end else begin
            cls = CL_BRK;
        end
    end

    assign active = (in_lvl_reg == polarity_reg);

    // Decode one pulse
    always_comb begin
        phase_next    = phase_reg;
        exp_lvl_next  = exp_lvl_reg;
        in_resp_next  = in_resp_reg;
        await_nb_next = await_nb_reg;
        bit_idx_next  = bit_idx_reg;
        shift_next    = shift_reg;
        data_len_next = data_len_reg;
        resp_len_next = resp_len_reg;
        crc_next      = crc_reg;
        eod_next      = eod_reg;
        nb_next       = nb_reg;
        nbl_next      = nbl_reg;
        status_next   = status_reg;
        byte_vld      = 1'b0;
        byte_kind     = KIND_DATA;
        byte_status   = ST_OK;
        fin_vld       = 1'b0;
        fin_status    = ST_OK;
        conc          = 1'b0;
        one_bit       = 1'b0;
        cur_len       = '0;

        // Clear everything on a new capture
        if (in_start_reg) begin
            phase_next    = PH_IDLE;
            in_resp_next  = 1'b0;
            await_nb_next = 1'b0;
            bit_idx_next  = '0;
            shift_next    = '0;
            data_len_next = '0;
            resp_len_next = '0;
            crc_next      = CRC_INIT;
            eod_next      = 1'b0;
            nb_next       = 1'b0;
            nbl_next      = 1'b0;
            status_next   = ST_EMPTY;
        end
        if (phase_next == PH_IDLE) begin
            exp_lvl_next = ~polarity_reg;
        end

        if (phase_next == PH_DONE) begin
            // ignore until next capture
        end else if (in_width_reg == '0) begin
            // End-of-capture marker
            if (phase_next == PH_IDLE) begin
                fin_vld    = 1'b1;
                fin_status = ST_EMPTY;
            end else begin
                conc = 1'b1;
            end
        end else if (phase_next == PH_IDLE) begin
            // Look for the first active pulse
            if (!active) begin
                if (in_end_reg) begin
                    fin_vld    = 1'b1;
                    fin_status = ST_EMPTY;
                end
            end else begin
                case (cls)
                    CL_MARK: begin
                        status_next = ST_OK;
                    end
                    CL_BRK: begin
                        fin_vld    = 1'b1;
                        fin_status = ST_BREAK;
                    end
                    CL_SHORT, CL_LONG: begin
                        status_next  = ST_RESP;
                        in_resp_next = 1'b1;
                        nb_next      = 1'b1;
                        if (cls == CL_LONG) begin
                            nbl_next = 1'b1;
                        end
                    end
                    default: begin
                        fin_vld    = 1'b1;
                        fin_status = ST_NOSOF;
                    end
                endcase
                if (!fin_vld) begin
                    exp_lvl_next = ~polarity_reg;
                    phase_next   = PH_RUN;
                    conc         = in_end_reg;
                end
            end
        end else if (in_lvl_reg != exp_lvl_next) begin
            fin_vld    = 1'b1;
            fin_status = ST_BADSYM;
        end else begin
            exp_lvl_next = ~exp_lvl_next;
            if (cls == CL_BAD) begin
                fin_vld    = 1'b1;
                fin_status = ST_BADSYM;
            end else if (cls == CL_BRK) begin
                if (active) begin
                    fin_vld    = 1'b1;
                    fin_status = ST_BREAK;
                end else begin
                    conc = 1'b1;
                end
            end else if (cls == CL_MARK) begin
                // EOD, or end of frame after the response
                if (active) begin
                    fin_vld    = 1'b1;
                    fin_status = ST_BADSYM;
                end else if (in_resp_next) begin
                    conc = 1'b1;
                end else if (bit_idx_next != '0) begin
                    fin_vld    = 1'b1;
                    fin_status = ST_FRAMING;
                end else begin
                    in_resp_next  = 1'b1;
                    await_nb_next = 1'b1;
                    eod_next      = 1'b1;
                    conc          = in_end_reg;
                end
            end else if (await_nb_next) begin
                // Normalization bit
                await_nb_next = 1'b0;
                nb_next       = 1'b1;
                if (cls == CL_LONG) begin
                    nbl_next = 1'b1;
                end
                conc = in_end_reg;
            end else begin
                // Data bit, MSB first
                one_bit = active ? (cls == CL_SHORT) : (cls == CL_LONG);
                cur_len = in_resp_next ? resp_len_next : data_len_next;
                if (bit_idx_next == '0 && cur_len >= MAX_BYTES) begin
                    fin_vld    = 1'b1;
                    fin_status = ST_TOOLONG;
                end else begin
                    if (bit_idx_next == '0) begin
                        shift_next = '0;
                    end
                    shift_next   = {shift_next[BYTE_W-2:0], one_bit};
                    bit_idx_next = bit_idx_next + BIT_W'(1);
                    if (bit_idx_next == '0) begin
                        byte_vld = 1'b1;
                        if (in_resp_next) begin
                            resp_len_next = resp_len_next + COUNT_W'(1);
                            byte_kind     = KIND_RESP;
                        end else begin
                            data_len_next = data_len_next + COUNT_W'(1);
                            crc_next      = crc8_step(crc_next, shift_next);
                            byte_kind     = KIND_DATA;
                        end
                    end
                    conc = in_end_reg;
                end
            end
        end

        // Close the capture with a status
        if (conc) begin
            fin_vld = 1'b1;
            if (bit_idx_next != '0) begin
                fin_status = ST_FRAMING;
            end else if (status_next == ST_RESP) begin
                fin_status = (resp_len_next == '0) ? ST_EMPTY : ST_RESP;
            end else if (data_len_next < COUNT_W'(2)) begin
                fin_status = ST_SHORT;
            end else begin
                fin_status = (crc_next == CRC_RESIDUE) ? status_next : ST_BADCRC;
            end
        end

        byte_status = status_next;
        if (fin_vld) begin
            phase_next  = PH_DONE;
            status_next = fin_status;
        end
    end

    // Commit decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            exp_lvl_reg  <= 1'b0;
            in_resp_reg  <= 1'b0;
            await_nb_reg <= 1'b0;
            bit_idx_reg  <= '0;
            shift_reg    <= '0;
            data_len_reg <= '0;
            resp_len_reg <= '0;
            crc_reg      <= CRC_INIT;
            eod_reg      <= 1'b0;
            nb_reg       <= 1'b0;
            nbl_reg      <= 1'b0;
            status_reg   <= ST_EMPTY;
        end else if (proc_fire) begin
            phase_reg    <= phase_next;
            exp_lvl_reg  <= exp_lvl_next;
            in_resp_reg  <= in_resp_next;
            await_nb_reg <= await_nb_next;
            bit_idx_reg  <= bit_idx_next;
            shift_reg    <= shift_next;
            data_len_reg <= data_len_next;
            resp_len_reg <= resp_len_next;
            crc_reg      <= crc_next;
            eod_reg      <= eod_next;
            nb_reg       <= nb_next;
            nbl_reg      <= nbl_next;
            status_reg   <= status_next;
        end
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    result_t            q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  q_wr_reg;
    logic [QPTR_W-1:0]  q_rd_reg;
    result_t            res_byte;
    result_t            res_fin;
    result_t            q_head;
    logic               push_byte;
    logic               push_fin;
    logic               q_pop;
    logic [QPTR_W-1:0]  fin_addr;
    logic [QCNT_W-1:0]  n_push;

    // Build both result candidates
    always_comb begin
        res_byte.last           = 1'b0;
        res_byte.kind           = byte_kind;
        res_byte.norm_bit_long  = nbl_next;
        res_byte.norm_bit_seen  = nb_next;
        res_byte.eod_seen       = eod_next;
        res_byte.response_count = resp_len_next;
        res_byte.data_count     = data_len_next;
        res_byte.frame_status   = byte_status;
        res_byte.byte_value     = shift_next;

        res_fin                 = res_byte;
        res_fin.last            = 1'b1;
        res_fin.kind            = KIND_STATUS;
        res_fin.frame_status    = fin_status;
        res_fin.byte_value      = '0;
    end

    assign push_byte = proc_fire && byte_vld;
    assign push_fin  = proc_fire && fin_vld;
    assign fin_addr  = push_byte ? q_wr_reg + QPTR_W'(1) : q_wr_reg;
    assign n_push    = QCNT_W'(push_byte) + QCNT_W'(push_fin);
    assign q_pop     = m_tvalid && m_tready;

    // Store results, byte first
    always_ff @(posedge aclk) begin
        if (push_byte) begin
            q_mem[q_wr_reg] <= res_byte;
        end
        if (push_fin) begin
            q_mem[fin_addr] <= res_fin;
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end else begin
            q_wr_reg  <= q_wr_reg + QPTR_W'(n_push);
            q_rd_reg  <= q_rd_reg + QPTR_W'(q_pop);
            q_cnt_reg <= q_cnt_reg + n_push - QCNT_W'(q_pop);
        end
    end

    assign q_head   = q_mem[q_rd_reg];
    assign m_tvalid = (q_cnt_reg != '0);
    assign m_tuser  = q_head.kind;
    assign m_tlast  = q_head.last;
    assign m_tdata  = {1'b0, q_head.norm_bit_long, q_head.norm_bit_seen, q_head.eod_seen,
                       q_head.response_count, q_head.data_count, q_head.frame_status,
                       q_head.byte_value};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_last_is_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == KIND_STATUS)))
        else $error("tlast does not match status kind");

    a_fin_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && fin_vld) |=> (phase_reg == PH_DONE))
        else $error("status issued without closing the capture");

    a_done_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && phase_reg == PH_DONE && !in_start_reg) |-> (n_push == '0))
        else $error("result produced after capture closed");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:12] <= MAX_BYTES && m_tdata[19:16] <= MAX_BYTES))
        else $error("byte count beyond limit");

endmodule

`default_nettype wire
